>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lps_pkg.sv
// Shared constants, types and elaboration-time functions of the lognormal sampler.
package lps_pkg;

    localparam int UB         = 24;            // uniform fraction bits
    localparam int IN_W       = 24;
    localparam int CFG_W      = 24;
    localparam int OUT_W      = 48;
    localparam int FB         = UB - 1;
    localparam int U2W        = 2 * FB + 1;
    localparam int R2W        = 2 * FB + 2;
    localparam int QW         = 33;
    localparam int DIV_STEPS  = QW;
    localparam int MW         = 31;            // Q1.30 mantissa
    localparam int FRAC_BITS  = 24;
    localparam int PW         = $clog2(R2W);
    localparam int LW         = PW + FRAC_BITS;
    localparam int KW         = 31;
    localparam int GW         = 31;
    localparam int N2W        = 32;
    localparam int SQW        = N2W + 24;
    localparam int SQ_STEPS   = SQW / 2;
    localparam int NW         = SQ_STEPS + 1;  // signed normal deviate
    localparam int SPW        = CFG_W + NW;
    localparam int TRW        = 30;
    localparam int YW         = 32;
    localparam int AW         = 32;
    localparam int EXP_STEPS  = 24;
    localparam int IPW        = YW - EXP_STEPS;
    localparam int EW         = 64;
    localparam int ZW         = EW + 2;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [KW-1:0]        K_2LN2  = KW'(1488522236);
    localparam logic signed [31:0]   K_LOG2E = 32'sd1549082005;
    localparam logic signed [SPW-1:0] T_LIM  = SPW'(24 * (1 << 24));

    localparam logic signed [CFG_W-1:0] SIGMA_RESET = CFG_W'(65536);

    typedef enum logic [1:0] {
        REG_SIGMA = 2'd0,
        REG_MU    = 2'd1,
        REG_GAMMA = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] sigma;
        logic signed [CFG_W-1:0] mu;
        logic signed [CFG_W-1:0] gamma;
    } cfg_t;

    typedef struct packed {
        logic           vld;
        logic           uneg;
        logic [U2W-1:0] u2;
        logic [R2W-1:0] r2;
    } div_in_t;

    typedef struct packed {
        logic           vld;
        logic           uneg;
        logic [QW-1:0]  q;
        logic [R2W-1:0] r2;
    } log_in_t;

    typedef struct packed {
        logic           vld;
        logic           uneg;
        logic [N2W-1:0] n2;
    } sqrt_in_t;

    typedef struct packed {
        logic                 vld;
        logic signed [NW-1:0] normal;
    } exp_in_t;

    typedef struct packed {
        logic                    vld;
        logic signed [OUT_W-1:0] sample;
        logic                    sat;
    } result_t;

    function automatic logic [63:0] isqrt_c(input logic [63:0] x);
        logic [63:0] xx;
        logic [63:0] res;
        logic [63:0] bitv;
        xx   = x;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (xx >= res + bitv)
            begin
                xx  = xx - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-n) in Q2.30, by repeated integer square roots of 2.0
    function automatic logic [AW-1:0] exp_root(input int n);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < n; i++)
        begin
            r = isqrt_c(r << 30);
        end
        return r[AW-1:0];
    endfunction

endpackage

>>> design/lognormal_polar_sampler.sv
// Top level of the lognormal sampler: register file, front stages and pipeline sections.
//
// Use: each transaction on the uniform channel (uniform_valid/uniform_ready) carries two
// 0.24 uniform fractions. They map to u, v in [-1,1); pairs with r^2 = 0 or r^2 > 1 are
// dropped inside the pipeline and never show up on the sample channel. Every kept pair
// yields one transaction on the sample channel (sample_valid/sample_ready): the signed
// Q24.24 value exp(sigma*n + mu) + gamma and a saturation flag.
// Throughput: one pair per cycle, with no gaps between pairs, unless the output stalls.
// Pipeline: 3 front stages (map, square, sum), 33 divider stages (one quotient bit each),
// 28 log stages (24 of them squaring steps), 29 square-root stages and 29 exponent
// stages (24 root-product steps); the length is set by the bit-serial divide, log and
// root chains.
// Stall: the whole pipeline holds while a sample waits and sample_ready is low; the
// output register keeps the sample and uniform_ready drops, so nothing is lost or
// repeated. Bubbles from rejected pairs travel as invalid stages.
// Reset: rst_n clears all valid bits at once; sigma = 1.0, mu = 0 and gamma = 0.
// Registers (APB, byte address 4*i): sigma_scale, log_mean, location_shift, Q8.16; write
// them only while the pipeline is empty.
module lognormal_polar_sampler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lps_pkg::ADDR_W-1:0]   paddr,
    input  logic [lps_pkg::DATA_W-1:0]   pwdata,
    output logic [lps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         uniform_valid,
    output logic                         uniform_ready,
    input  logic [lps_pkg::IN_W-1:0]     uniform_first,
    input  logic [lps_pkg::IN_W-1:0]     uniform_second,
    output logic                         sample_valid,
    input  logic                         sample_ready,
    output logic signed [lps_pkg::OUT_W-1:0] sample_value,
    output logic                         saturated
);
    import lps_pkg::*;

    localparam logic [UB-1:0]  HALF   = UB'(1) << FB;
    localparam logic [R2W-1:0] R2_ONE = R2W'(1) << (2 * FB);

    // configuration
    cfg_t       cfg_reg;
    reg_idx_t   widx;
    reg_idx_t   ridx;
    logic       wr_en;

    // front stages
    logic            f1_vld_reg;
    logic            f1_uneg_reg;
    logic [UB-1:0]   ua_reg;
    logic [UB-1:0]   vb_reg;
    logic [UB-1:0]   a_in;
    logic [UB-1:0]   b_in;
    logic            f2_vld_reg;
    logic            f2_uneg_reg;
    logic [U2W-1:0]  u2_reg;
    logic [U2W-1:0]  v2_reg;
    logic [2*UB-1:0] u2_full;
    logic [2*UB-1:0] v2_full;
    logic [R2W-1:0]  r2_sum;
    div_in_t         div_in_reg;

    // pipeline control
    logic     en;
    log_in_t  log_in;
    sqrt_in_t sqrt_in;
    exp_in_t  exp_in;
    result_t  res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign ridx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register writes; unknown addresses are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma <= SIGMA_RESET;
            cfg_reg.mu    <= '0;
            cfg_reg.gamma <= '0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_SIGMA: cfg_reg.sigma <= pwdata[CFG_W-1:0];
                REG_MU:    cfg_reg.mu    <= pwdata[CFG_W-1:0];
                REG_GAMMA: cfg_reg.gamma <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    // read back sign-extended
    always_comb
    begin
        unique case (ridx)
            REG_SIGMA: prdata = DATA_W'(cfg_reg.sigma);
            REG_MU:    prdata = DATA_W'(cfg_reg.mu);
            REG_GAMMA: prdata = DATA_W'(cfg_reg.gamma);
            default:   prdata = '0;
        endcase
    end

    // advance every stage unless a finished sample is held
    assign en            = !res.vld || sample_ready;
    assign uniform_ready = en;

    // map to |u|, |v| with the sign of u
    assign a_in = uniform_first[UB-1:0];
    assign b_in = uniform_second[UB-1:0];

    assign u2_full = ua_reg * ua_reg;
    assign v2_full = vb_reg * vb_reg;
    assign r2_sum  = {1'b0, u2_reg} + {1'b0, v2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            div_in_reg <= '0;
        end
        else if (en)
        begin
            f1_vld_reg      <= uniform_valid;
            f2_vld_reg      <= f1_vld_reg;
            // drop pairs outside the unit circle or at the origin
            div_in_reg.vld  <= f2_vld_reg && (r2_sum != '0) && (r2_sum <= R2_ONE);
            div_in_reg.uneg <= f2_uneg_reg;
            div_in_reg.u2   <= u2_reg;
            div_in_reg.r2   <= r2_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_uneg_reg <= a_in < HALF;
            ua_reg      <= (a_in >= HALF) ? a_in - HALF : HALF - a_in;
            vb_reg      <= (b_in >= HALF) ? b_in - HALF : HALF - b_in;
            f2_uneg_reg <= f1_uneg_reg;
            u2_reg      <= u2_full[U2W-1:0];
            v2_reg      <= v2_full[U2W-1:0];
        end
    end

    lps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (div_in_reg),
        .dout  (log_in)
    );

    lps_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (log_in),
        .dout  (sqrt_in)
    );

    lps_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (sqrt_in),
        .dout  (exp_in)
    );

    lps_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .din   (exp_in),
        .dout  (res)
    );

    assign sample_valid = res.vld;
    assign sample_value = res.sample;
    assign saturated    = res.sat;

endmodule

>>> design/lps_divider.sv
// Restoring divider pipeline: u^2 / r^2 as a 33-bit Q1.32 quotient, one quotient bit per stage.
module lps_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  lps_pkg::div_in_t din,
    output lps_pkg::log_in_t dout
);
    import lps_pkg::*;

    logic           vld_reg  [0:DIV_STEPS-1];
    logic           uneg_reg [0:DIV_STEPS-1];
    logic [R2W-1:0] r2_reg   [0:DIV_STEPS-1];
    logic [R2W-1:0] rem_reg  [0:DIV_STEPS-1];
    logic [R2W-1:0] rem_next [0:DIV_STEPS-1];
    logic [QW-1:0]  q_reg    [0:DIV_STEPS-1];
    logic [QW-1:0]  q_next   [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic           vld_prev;
        logic           uneg_prev;
        logic [R2W-1:0] r2_prev;
        logic [R2W-1:0] rem_sh;
        logic [QW-1:0]  q_sh;

        if (k == 0)
        begin : g_first
            assign vld_prev  = din.vld;
            assign uneg_prev = din.uneg;
            assign r2_prev   = din.r2;
            assign rem_sh    = {1'b0, din.u2};
            assign q_sh      = '0;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign uneg_prev = uneg_reg[k-1];
            assign r2_prev   = r2_reg[k-1];
            assign rem_sh    = {rem_reg[k-1][R2W-2:0], 1'b0};
            assign q_sh      = {q_reg[k-1][QW-2:0], 1'b0};
        end

        always_comb
        begin
            if (rem_sh >= r2_prev)
            begin
                rem_next[k] = rem_sh - r2_prev;
                q_next[k]   = {q_sh[QW-1:1], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh;
                q_next[k]   = q_sh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                uneg_reg[k] <= uneg_prev;
                r2_reg[k]   <= r2_prev;
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
            end
        end
    end

    assign dout.vld  = vld_reg[DIV_STEPS-1];
    assign dout.uneg = uneg_reg[DIV_STEPS-1];
    assign dout.q    = q_reg[DIV_STEPS-1];
    assign dout.r2   = r2_reg[DIV_STEPS-1];

endmodule

>>> design/lps_log.sv
// Log pipeline: -2 ln(r^2) by normalization and 24 squaring stages, then scale by u^2/r^2.
module lps_log (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  lps_pkg::log_in_t  din,
    output lps_pkg::sqrt_in_t dout
);
    import lps_pkg::*;

    // leading-one stage
    logic           p_vld_reg;
    logic           p_uneg_reg;
    logic [QW-1:0]  p_q_reg;
    logic [R2W-1:0] p_r2_reg;
    logic [PW-1:0]  p_reg;
    logic [PW-1:0]  p_next;

    // normalize stage
    logic              m_vld_reg;
    logic              m_uneg_reg;
    logic [QW-1:0]     m_q_reg;
    logic [PW-1:0]     diff_reg;
    logic [MW-1:0]     m_reg;
    logic [R2W+MW-1:0] ext_next;
    logic [PW-1:0]     shamt;

    // squaring stages
    logic                 sq_vld_reg  [0:FRAC_BITS-1];
    logic                 sq_uneg_reg [0:FRAC_BITS-1];
    logic [QW-1:0]        sq_q_reg    [0:FRAC_BITS-1];
    logic [PW-1:0]        sq_diff_reg [0:FRAC_BITS-1];
    logic [MW-1:0]        sq_m_reg    [0:FRAC_BITS-1];
    logic [MW-1:0]        sq_m_next   [0:FRAC_BITS-1];
    logic [FRAC_BITS-1:0] sq_frac_reg [0:FRAC_BITS-1];
    logic [FRAC_BITS-1:0] sq_frac_next[0:FRAC_BITS-1];

    // scale stages
    logic             g_vld_reg;
    logic             g_uneg_reg;
    logic [QW-1:0]    g_q_reg;
    logic [GW-1:0]    g_reg;
    logic [LW:0]      l_full;
    logic [LW-1:0]    l_val;
    logic [LW+KW-1:0] g_prod;

    logic             n_vld_reg;
    logic             n_uneg_reg;
    logic [N2W-1:0]   n2_reg;
    logic [QW+GW-1:0] n_prod;

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < R2W; i++)
        begin
            if (din.r2[i])
                p_next = PW'(i);
        end
    end

    assign shamt    = PW'(R2W - 1) - p_reg;
    assign ext_next = {p_r2_reg, {MW{1'b0}}} << shamt;

    for (genvar s = 0; s < FRAC_BITS; s++)
    begin : g_sq
        logic                 vld_prev;
        logic                 uneg_prev;
        logic [QW-1:0]        q_prev;
        logic [PW-1:0]        diff_prev;
        logic [MW-1:0]        m_prev;
        logic [FRAC_BITS-1:0] frac_prev;
        logic [2*MW-1:0]      mm;
        logic [MW:0]          mm_hi;

        if (s == 0)
        begin : g_first
            assign vld_prev  = m_vld_reg;
            assign uneg_prev = m_uneg_reg;
            assign q_prev    = m_q_reg;
            assign diff_prev = diff_reg;
            assign m_prev    = m_reg;
            assign frac_prev = '0;
        end
        else
        begin : g_rest
            assign vld_prev  = sq_vld_reg[s-1];
            assign uneg_prev = sq_uneg_reg[s-1];
            assign q_prev    = sq_q_reg[s-1];
            assign diff_prev = sq_diff_reg[s-1];
            assign m_prev    = sq_m_reg[s-1];
            assign frac_prev = sq_frac_reg[s-1];
        end

        assign mm    = m_prev * m_prev;
        assign mm_hi = mm[2*MW-1:MW-1];

        // renormalize into [1,2) and shift out one fraction bit
        always_comb
        begin
            if (mm_hi[MW])
            begin
                sq_m_next[s]    = mm_hi[MW:1];
                sq_frac_next[s] = {frac_prev[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                sq_m_next[s]    = mm_hi[MW-1:0];
                sq_frac_next[s] = {frac_prev[FRAC_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[s] <= 1'b0;
            else if (en)
                sq_vld_reg[s] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_uneg_reg[s] <= uneg_prev;
                sq_q_reg[s]    <= q_prev;
                sq_diff_reg[s] <= diff_prev;
                sq_m_reg[s]    <= sq_m_next[s];
                sq_frac_reg[s] <= sq_frac_next[s];
            end
        end
    end

    // -log2(r2) in Q.24, clamped at zero, then times 2 ln 2
    assign l_full = {1'b0, sq_diff_reg[FRAC_BITS-1], {FRAC_BITS{1'b0}}}
                  - {{(PW+1){1'b0}}, sq_frac_reg[FRAC_BITS-1]};
    assign l_val  = l_full[LW] ? '0 : l_full[LW-1:0];
    assign g_prod = l_val * K_2LN2;
    assign n_prod = g_q_reg * g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= din.vld;
            m_vld_reg <= p_vld_reg;
            g_vld_reg <= sq_vld_reg[FRAC_BITS-1];
            n_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_uneg_reg <= din.uneg;
            p_q_reg    <= din.q;
            p_r2_reg   <= din.r2;
            p_reg      <= p_next;
            m_uneg_reg <= p_uneg_reg;
            m_q_reg    <= p_q_reg;
            m_reg      <= ext_next[R2W+MW-1 -: MW];
            diff_reg   <= PW'(2 * FB) - p_reg;
            g_uneg_reg <= sq_uneg_reg[FRAC_BITS-1];
            g_q_reg    <= sq_q_reg[FRAC_BITS-1];
            g_reg      <= g_prod[LW+KW-1 -: GW];
            n_uneg_reg <= g_uneg_reg;
            n2_reg     <= n_prod[QW+GW-1 -: N2W];
        end
    end

    assign dout.vld  = n_vld_reg;
    assign dout.uneg = n_uneg_reg;
    assign dout.n2   = n2_reg;

endmodule

>>> design/lps_isqrt.sv
// Square-root pipeline: one result bit per stage, then the sign of u is applied.
module lps_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  lps_pkg::sqrt_in_t din,
    output lps_pkg::exp_in_t  dout
);
    import lps_pkg::*;

    logic           vld_reg  [0:SQ_STEPS-1];
    logic           uneg_reg [0:SQ_STEPS-1];
    logic [SQW-1:0] x_reg    [0:SQ_STEPS-1];
    logic [SQW-1:0] x_next   [0:SQ_STEPS-1];
    logic [SQW-1:0] res_reg  [0:SQ_STEPS-1];
    logic [SQW-1:0] res_next [0:SQ_STEPS-1];

    logic                 sgn_vld_reg;
    logic signed [NW-1:0] normal_reg;
    logic [NW-1:0]        nmag;

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_step
        localparam logic [SQW-1:0] BITV = SQW'(1) << (SQW - 2 - 2 * s);
        logic           vld_prev;
        logic           uneg_prev;
        logic [SQW-1:0] x_prev;
        logic [SQW-1:0] res_prev;
        logic [SQW-1:0] trial;

        if (s == 0)
        begin : g_first
            assign vld_prev  = din.vld;
            assign uneg_prev = din.uneg;
            assign x_prev    = {din.n2, {(SQW-N2W){1'b0}}};
            assign res_prev  = '0;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign uneg_prev = uneg_reg[s-1];
            assign x_prev    = x_reg[s-1];
            assign res_prev  = res_reg[s-1];
        end

        assign trial = res_prev + BITV;

        always_comb
        begin
            if (x_prev >= trial)
            begin
                x_next[s]   = x_prev - trial;
                res_next[s] = (res_prev >> 1) + BITV;
            end
            else
            begin
                x_next[s]   = x_prev;
                res_next[s] = res_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                uneg_reg[s] <= uneg_prev;
                x_reg[s]    <= x_next[s];
                res_reg[s]  <= res_next[s];
            end
        end
    end

    assign nmag = {1'b0, res_reg[SQ_STEPS-1][NW-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sgn_vld_reg <= 1'b0;
        else if (en)
            sgn_vld_reg <= vld_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            normal_reg <= uneg_reg[SQ_STEPS-1] ? -$signed(nmag) : $signed(nmag);
    end

    assign dout.vld    = sgn_vld_reg;
    assign dout.normal = normal_reg;

endmodule

>>> design/lps_exp.sv
// Exponent pipeline: sigma*n + mu, range checks, 2^x by root products, shift, add and clamp.
module lps_exp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  lps_pkg::cfg_t    cfg,
    input  lps_pkg::exp_in_t din,
    output lps_pkg::result_t dout
);
    import lps_pkg::*;

    localparam logic signed [ZW-1:0] Z_MAX = ZW'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [ZW-1:0] Z_MIN = -Z_MAX - ZW'(1);

    // stage A: sigma * normal
    logic                  a_vld_reg;
    logic signed [SPW-1:0] prod_reg;
    logic signed [SPW-1:0] prod_next;

    // stage B: t with range flags
    logic                  b_vld_reg;
    logic                  b_big_reg;
    logic                  b_small_reg;
    logic signed [TRW-1:0] t_reg;
    logic signed [SPW-1:0] mu_ext;
    logic signed [SPW-1:0] t_next;

    // stage C: t * log2(e)
    logic                     c_vld_reg;
    logic                     c_big_reg;
    logic                     c_small_reg;
    logic signed [YW-1:0]     y_reg;
    logic signed [TRW+31:0]   y_full;

    // root product stages
    logic                 x_vld_reg   [0:EXP_STEPS-1];
    logic                 x_big_reg   [0:EXP_STEPS-1];
    logic                 x_small_reg [0:EXP_STEPS-1];
    logic [YW-1:0]        x_y_reg     [0:EXP_STEPS-1];
    logic [AW-1:0]        acc_reg     [0:EXP_STEPS-1];
    logic [AW-1:0]        acc_next    [0:EXP_STEPS-1];

    // stage D: shift by the integer part
    logic                 d_vld_reg;
    logic                 d_big_reg;
    logic [EW-1:0]        e_reg;
    logic [EW-1:0]        e_next;
    logic signed [IPW:0]  sh;
    logic [IPW:0]         sh_neg;

    // stage E: add shift and clamp
    logic                    e_vld_reg;
    logic signed [OUT_W-1:0] sample_reg;
    logic                    sat_reg;
    logic signed [ZW-1:0]    gamma_ext;
    logic signed [ZW-1:0]    z_sum;
    logic signed [OUT_W-1:0] sample_next;
    logic                    sat_next;

    assign prod_next = $signed(cfg.sigma) * $signed(din.normal);
    assign mu_ext    = $signed(cfg.mu);
    assign t_next    = (prod_reg >>> 16) + (mu_ext <<< 8);
    assign y_full    = t_reg * K_LOG2E;

    for (genvar s = 0; s < EXP_STEPS; s++)
    begin : g_root
        localparam logic [AW-1:0] ROOT = exp_root(s + 1);
        logic            vld_prev;
        logic            big_prev;
        logic            small_prev;
        logic [YW-1:0]   y_prev;
        logic [AW-1:0]   acc_prev;
        logic [2*AW-1:0] mul;

        if (s == 0)
        begin : g_first
            assign vld_prev   = c_vld_reg;
            assign big_prev   = c_big_reg;
            assign small_prev = c_small_reg;
            assign y_prev     = y_reg;
            assign acc_prev   = AW'(1) << 30;
        end
        else
        begin : g_rest
            assign vld_prev   = x_vld_reg[s-1];
            assign big_prev   = x_big_reg[s-1];
            assign small_prev = x_small_reg[s-1];
            assign y_prev     = x_y_reg[s-1];
            assign acc_prev   = acc_reg[s-1];
        end

        assign mul = acc_prev * ROOT;

        always_comb
        begin
            if (y_prev[EXP_STEPS-1-s])
                acc_next[s] = mul[AW+29:30];
            else
                acc_next[s] = acc_prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                x_vld_reg[s] <= 1'b0;
            else if (en)
                x_vld_reg[s] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_big_reg[s]   <= big_prev;
                x_small_reg[s] <= small_prev;
                x_y_reg[s]     <= y_prev;
                acc_reg[s]     <= acc_next[s];
            end
        end
    end

    assign sh     = $signed({x_y_reg[EXP_STEPS-1][YW-1], x_y_reg[EXP_STEPS-1][YW-1 -: IPW]})
                  - (IPW+1)'(6);
    assign sh_neg = -sh;

    always_comb
    begin
        if (x_small_reg[EXP_STEPS-1])
            e_next = '0;
        else if (!sh[IPW])
            e_next = {{(EW-AW){1'b0}}, acc_reg[EXP_STEPS-1]} << sh[IPW-1:0];
        else
            e_next = {{(EW-AW){1'b0}}, acc_reg[EXP_STEPS-1]} >> sh_neg[IPW-1:0];
    end

    assign gamma_ext = $signed(cfg.gamma);
    assign z_sum     = $signed({2'b00, e_reg}) + (gamma_ext <<< 8);

    always_comb
    begin
        if (d_big_reg || z_sum > Z_MAX)
        begin
            sample_next = Z_MAX[OUT_W-1:0];
            sat_next    = 1'b1;
        end
        else if (z_sum < Z_MIN)
        begin
            sample_next = Z_MIN[OUT_W-1:0];
            sat_next    = 1'b1;
        end
        else
        begin
            sample_next = z_sum[OUT_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= din.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= x_vld_reg[EXP_STEPS-1];
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            b_big_reg   <= t_next > T_LIM;
            b_small_reg <= t_next < -T_LIM;
            t_reg       <= t_next[TRW-1:0];
            c_big_reg   <= b_big_reg;
            c_small_reg <= b_small_reg;
            y_reg       <= y_full[TRW+31 -: YW];
            d_big_reg   <= x_big_reg[EXP_STEPS-1];
            e_reg       <= e_next;
            sample_reg  <= sample_next;
            sat_reg     <= sat_next;
        end
    end

    assign dout.vld    = e_vld_reg;
    assign dout.sample = sample_reg;
    assign dout.sat    = sat_reg;

endmodule

>>> design/lps_checker.sv
// Port-level checker for the lognormal sampler and its bind to the top level.
`include "assert_macros.svh"

module lps_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             uniform_valid,
    input logic                             uniform_ready,
    input logic                             sample_valid,
    input logic                             sample_ready,
    input logic signed [lps_pkg::OUT_W-1:0] sample_value,
    input logic                             saturated
);
    import lps_pkg::*;

    localparam logic signed [OUT_W-1:0] S_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] S_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // hold a stalled sample
    `LPS_ASSERT_NXT(a_hold, clk, rst_n, sample_valid && !sample_ready, sample_valid && $stable(sample_value) && $stable(saturated), "stalled sample changed")

    // a saturated sample sits at one of the rails
    `LPS_ASSERT_IMP(a_rail, clk, rst_n, sample_valid && saturated, sample_value == S_MAX || sample_value == S_MIN, "saturated sample off the rails")

    // accept new pairs exactly when the pipeline advances
    `LPS_ASSERT_IMP(a_ready, clk, rst_n, uniform_valid || !uniform_valid, uniform_ready == (!sample_valid || sample_ready), "input ready out of step with output")

endmodule

bind lognormal_polar_sampler lps_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .uniform_valid (uniform_valid),
    .uniform_ready (uniform_ready),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample_value  (sample_value),
    .saturated     (saturated)
);

>>> verif/testbench.sv
// Self-checking testbench for the lognormal polar sampler.
`timescale 1ns / 100ps

module testbench;
    import lps_pkg::*;

    localparam int            PIPE_DRAIN = 130;  // pipeline depth plus margin
    localparam logic [23:0]   HALF       = 24'h800000;
    localparam longint signed OUT_HI     = 64'sh7FFF_FFFF_FFFF;
    localparam longint signed OUT_LO     = -OUT_HI - 1;
    localparam longint signed T_BOUND    = 24 * (64'sd1 << 24);

    typedef struct {
        logic [47:0] value;
        logic        sat;
    } sample_t;

    // Lognormal predictor and queue of predicted samples.
    class sample_scoreboard;
        longint signed sigma;
        longint signed mu;
        longint signed gamma;
        sample_t       pending_samples[$];
        int            errors;

        function new();
            sigma  = 65536;
            mu     = 0;
            gamma  = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [23:0] val);
            longint signed sv;
            sv = longint'(signed'(val));
            case (idx)
                REG_SIGMA: sigma = sv;
                REG_MU:    mu    = sv;
                REG_GAMMA: gamma = sv;
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // -log2(r) in Q.24, r in units of 2^-46
        function logic [63:0] neg_log2(logic [63:0] r);
            int          p;
            logic [63:0] m;
            logic [63:0] frac;
            longint      l;
            p    = 0;
            frac = 0;
            while (p < 63 && (r >> (p + 1)) != 0)
                p++;
            m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
            for (int j = 0; j < 24; j++)
            begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31))
                begin
                    m    = m >> 1;
                    frac = frac | 1;
                end
            end
            l = longint'(46 - p) * (64'sd1 << 24) - longint'(frac);
            return (l < 0) ? 64'd0 : 64'(l);
        endfunction

        // exp(t) in Q.24 for |t| <= 24.0
        function logic [63:0] exp_fixed(longint signed t);
            longint signed y;
            longint signed ip;
            longint signed sh;
            logic [63:0]   acc;
            logic [63:0]   root;
            y    = (t * 64'sd1549082005) >>> 30;
            ip   = y >>> 24;
            acc  = 64'd1 << 30;
            root = 64'd1 << 31;
            for (int j = 23; j >= 0; j--)
            begin
                root = int_sqrt(root << 30);
                if (y[j])
                    acc = (acc * root) >> 30;
            end
            sh = ip - 6;
            if (sh >= 0)
                return acc << sh;
            if (sh <= -63)
                return 0;
            return acc >> (-sh);
        endfunction

        // Note one accepted pair; queue its sample unless the pair is rejected.
        function void note_pair(logic [23:0] a, logic [23:0] b);
            logic [63:0]   ua, vb, u2, r2, q, rem, g, n2, nmag, e;
            longint signed nrm, t, z;
            logic          sat;
            sample_t       s;
            ua  = (a >= HALF) ? 64'(a - HALF) : 64'(HALF - a);
            vb  = (b >= HALF) ? 64'(b - HALF) : 64'(HALF - b);
            u2  = ua * ua;
            r2  = u2 + vb * vb;
            sat = 1'b0;
            if (r2 == 0 || r2 > (64'd1 << 46))
                return;
            // u^2 / r2 as Q.32, one quotient bit per step
            q   = 0;
            rem = u2;
            if (rem >= r2)
            begin
                q   = 1;
                rem = rem - r2;
            end
            for (int j = 0; j < 32; j++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= r2)
                begin
                    rem = rem - r2;
                    q   = q | 1;
                end
            end
            g    = (neg_log2(r2) * 64'd1488522236) >> 30;
            n2   = (q * g) >> 32;
            nmag = int_sqrt(n2 << 24);
            nrm  = (a < HALF) ? -longint'(nmag) : longint'(nmag);
            t    = ((sigma * nrm) >>> 16) + mu * 256;
            if (t > T_BOUND)
            begin
                z   = OUT_HI;
                sat = 1'b1;
            end
            else
            begin
                e = (t < -T_BOUND) ? 64'd0 : exp_fixed(t);
                z = longint'(e) + gamma * 256;
                if (z > OUT_HI)
                begin
                    z   = OUT_HI;
                    sat = 1'b1;
                end
                else if (z < OUT_LO)
                begin
                    z   = OUT_LO;
                    sat = 1'b1;
                end
            end
            s.value = z[47:0];
            s.sat   = sat;
            pending_samples.push_back(s);
        endfunction

        function void check_sample(logic [47:0] value, logic sat);
            sample_t s;
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample: sample_value=%h saturated=%b", value, sat);
                errors++;
                return;
            end
            s = pending_samples.pop_front();
            if (value !== s.value)
            begin
                $error("sample_value: expected %h, actual %h", s.value, value);
                errors++;
            end
            if (sat !== s.sat)
            begin
                $error("saturated: expected %b, actual %b", s.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               uniform_valid;
    logic               uniform_ready;
    logic [IN_W-1:0]    uniform_first;
    logic [IN_W-1:0]    uniform_second;
    logic               sample_valid;
    logic               sample_ready;
    logic signed [OUT_W-1:0] sample_value;
    logic               saturated;

    sample_scoreboard sb;
    bit               no_idle;
    int               n_samples;

    lognormal_polar_sampler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .uniform_valid  (uniform_valid),
        .uniform_ready  (uniform_ready),
        .uniform_first  (uniform_first),
        .uniform_second (uniform_second),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample_value   (sample_value),
        .saturated      (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Write one register through a setup and an access cycle; the block must be idle.
    task automatic write_reg(reg_idx_t idx, logic [23:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= {8'h00, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(logic [23:0] s, logic [23:0] m, logic [23:0] g);
        write_reg(REG_SIGMA, s);
        write_reg(REG_MU, m);
        write_reg(REG_GAMMA, g);
    endtask

    // Offer one pair after a random gap; hold valid until the transaction completes.
    task automatic send_pair(logic [23:0] a, logic [23:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            uniform_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        uniform_valid  <= 1'b1;
        uniform_first  <= a;
        uniform_second <= b;
        do
            @(posedge clk);
        while (!uniform_ready);
        sb.note_pair(a, b);
    endtask

    // Random pair: mostly full range, some near the center (tiny r2), with v = 0 or on an edge.
    task automatic send_random_pair();
        logic [23:0] a;
        logic [23:0] b;
        int          mode;
        mode = $urandom_range(0, 9);
        a    = 24'($urandom);
        b    = 24'($urandom);
        if (mode == 0)
        begin
            a = HALF + 24'($urandom_range(0, 64)) - 24'd32;
            b = HALF + 24'($urandom_range(0, 64)) - 24'd32;
        end
        else if (mode == 1)
            b = HALF;
        else if (mode == 2)
            a = ($urandom_range(0, 1) != 0) ? 24'h000000 : 24'hFFFFFF;
        send_pair(a, b);
    endtask

    // Pairs that hit the edges: rejects at r2 = 0 and r2 > 1, r2 exactly 1, tiny r2.
    task automatic send_directed();
        send_pair(24'h000000, 24'h000000);
        send_pair(HALF, HALF);
        send_pair(24'h000000, HALF);
        send_pair(HALF, 24'h000000);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'hFFFFFF, HALF);
        send_pair(HALF + 24'd1, HALF);
        send_pair(HALF - 24'd1, HALF);
        send_pair(HALF, HALF + 24'd1);
        send_pair(24'h000000, 24'hFFFFFF);
        send_pair(24'h2D413D, 24'h2D413D);
        send_pair(24'hD2BEC3, 24'h5A5A5A);
    endtask

    // Drop valid, let every sample arrive, then let rejected pairs drain.
    task automatic drain();
        uniform_valid <= 1'b0;
        while (sb.pending_samples.size() > 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_random_pair();
        drain();
    endtask

    // Receiver: random stall per sample, plus one long hold-off to back up the pipeline.
    initial
    begin
        int k;
        sample_ready <= 1'b0;
        n_samples = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            k = no_idle ? 0 : $urandom_range(0, 3);
            if (n_samples == 250)
                k = 600;
            if (k > 0)
            begin
                sample_ready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            sample_ready <= 1'b1;
            do
                @(posedge clk);
            while (!sample_valid);
            sb.check_sample(sample_value, saturated);
            n_samples++;
        end
    end

    initial
    begin
        sb             = new();
        no_idle        = 1'b0;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        uniform_valid  <= 1'b0;
        uniform_first  <= '0;
        uniform_second <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: sigma 1, mu 0, gamma 0.
        send_directed();
        random_phase(150);

        // Largest positive settings: exponent overflow and clamping.
        write_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_directed();
        random_phase(100);

        // Most negative settings: exponent underflow.
        write_config(24'h800000, 24'h800000, 24'h800000);
        send_directed();
        random_phase(100);

        // Zero sigma: the result hangs on mu and gamma alone.
        write_config(24'h000000, 24'($urandom_range(0, 1 << 19)) - 24'h040000,
                     24'($urandom));
        random_phase(100);

        // Moderate random settings; one phase runs at full rate on both sides.
        for (int ph = 0; ph < 4; ph++)
        begin
            no_idle = (ph == 2);
            write_config(24'($urandom_range(0, 1 << 18)) - 24'h020000,
                         24'($urandom_range(0, 1 << 20)) - 24'h080000,
                         24'($urandom));
            random_phase(220);
        end
        no_idle = 1'b0;

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> lognormal_polar_sampler.f
+incdir+design
design/lps_pkg.sv
design/lps_divider.sv
design/lps_log.sv
design/lps_isqrt.sv
design/lps_exp.sv
design/lognormal_polar_sampler.sv
design/lps_checker.sv
verif/testbench.sv
